/* rtl/kl_pkg.sv */
// Shared types, codes and keyword tables of the keyword lexer.
`default_nettype none
package kl_pkg;

    localparam int KL_MAX_WORD_LEN = 32;

    // Token kinds.
    localparam logic [3:0] KIND_IDENT  = 4'd0;
    localparam logic [3:0] KIND_PUB    = 4'd1;
    localparam logic [3:0] KIND_PROC   = 4'd2;
    localparam logic [3:0] KIND_U8     = 4'd3;
    localparam logic [3:0] KIND_RETURN = 4'd4;
    localparam logic [3:0] KIND_INT    = 4'd5;
    localparam logic [3:0] KIND_LPAREN = 4'd6;
    localparam logic [3:0] KIND_RPAREN = 4'd7;
    localparam logic [3:0] KIND_MINUS  = 4'd8;
    localparam logic [3:0] KIND_GT     = 4'd9;
    localparam logic [3:0] KIND_LBRACE = 4'd10;
    localparam logic [3:0] KIND_RBRACE = 4'd11;
    localparam logic [3:0] KIND_SEMI   = 4'd12;
    localparam logic [3:0] KIND_END    = 4'd13;
    localparam logic [3:0] KIND_ERROR  = 4'd14;

    // Scanner modes.
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;
    localparam logic [1:0] MODE_HALTED = 2'd3;

    // Keyword slots.
    localparam logic [1:0] KW_PUB    = 2'd0;
    localparam logic [1:0] KW_PROC   = 2'd1;
    localparam logic [1:0] KW_U8     = 2'd2;
    localparam logic [1:0] KW_RETURN = 2'd3;
    localparam int         KW_COUNT  = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic cont;
        logic rd_first;
        logic emit_one;
        logic emit_char;
        logic tail;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic halted;
        logic word_mode;
        logic num_mode;
        logic cont_char;
        logic kw_hit;
        logic tail_emits;
        logic out_free;
        logic idx_last;
    } t_status;

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] len;
        len = 3'd0;
        unique case (k)
            KW_PUB:    len = 3'd3;
            KW_PROC:   len = 3'd4;
            KW_U8:     len = 3'd2;
            KW_RETURN: len = 3'd6;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_byte(input logic [1:0] k, input logic [2:0] pos);
        logic [47:0] s;
        s = '0;
        unique case (k)
            KW_PUB:    s = {"pub", 24'h0};
            KW_PROC:   s = {"proc", 16'h0};
            KW_U8:     s = {"u8", 32'h0};
            KW_RETURN: s = "return";
            default:   s = '0;
        endcase
        s = s << (8 * pos);
        return s[47:40];
    endfunction

    function automatic logic [3:0] kw_kind(input logic [1:0] k);
        logic [3:0] kind;
        kind = KIND_IDENT;
        unique case (k)
            KW_PUB:    kind = KIND_PUB;
            KW_PROC:   kind = KIND_PROC;
            KW_U8:     kind = KIND_U8;
            KW_RETURN: kind = KIND_RETURN;
            default:   kind = KIND_IDENT;
        endcase
        return kind;
    endfunction

endpackage
`default_nettype wire

/* rtl/kl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/kl_ctrl.sv */
// Sequencing state machine of the keyword lexer.
`default_nettype none
module kl_ctrl import kl_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_ONE    = 3'd2;
    localparam logic [2:0] S_IDENT  = 3'd3;
    localparam logic [2:0] S_TAIL   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_do_tail;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        w_do_tail  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.halted) begin
                    n_state = S_IDLE;
                end else if (i_status.cont_char) begin
                    o_cmd.cont = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_status.word_mode && !i_status.kw_hit) begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_IDENT;
                end else if (i_status.word_mode || i_status.num_mode) begin
                    n_state = S_ONE;
                end else begin
                    w_do_tail = 1'b1;
                end
            end
            S_ONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit_one = 1'b1;
                    n_state        = S_TAIL;
                end
            end
            S_IDENT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_char = 1'b1;
                    if (i_status.idx_last) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                w_do_tail = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_do_tail) begin
            if (!i_status.tail_emits || i_status.out_free) begin
                o_cmd.tail = 1'b1;
                n_state    = S_IDLE;
            end else begin
                n_state = S_TAIL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* rtl/kl_dpath.sv */
// Datapath of the keyword lexer: scanner registers, counters and result register.
`default_nettype none
module kl_dpath import kl_pkg::*; #(
    parameter int MAX_WORD_LEN = KL_MAX_WORD_LEN,
    localparam int ADDR_W = $clog2(MAX_WORD_LEN),
    localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [7:0]        i_char,
    input  wire logic              i_end,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    output logic                   o_ram_we,
    output logic      [ADDR_W-1:0] o_ram_waddr,
    output logic      [7:0]        o_ram_wdata,
    output logic                   o_ram_re,
    output logic      [ADDR_W-1:0] o_ram_raddr,
    input  wire logic [7:0]        i_ram_rdata,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic      [3:0]        o_kind,
    output logic      [31:0]       o_value,
    output logic      [7:0]        o_text,
    output logic      [15:0]       o_line,
    output logic      [15:0]       o_col,
    output logic                   o_name_trunc,
    output logic                   o_token_end,
    output logic                   o_last
);

    // Latched input item.
    logic [7:0]  r_char, n_char;
    logic        r_end, n_end;
    // Scanner state.
    logic [1:0]          r_mode, n_mode;
    logic [LEN_W-1:0]    r_len, n_len;
    logic                r_ovf, n_ovf;
    logic [31:0]         r_acc, n_acc;
    logic [15:0]         r_line, n_line;
    logic [15:0]         r_col, n_col;
    logic [15:0]         r_pline, n_pline;
    logic [15:0]         r_pcol, n_pcol;
    logic [KW_COUNT-1:0] r_kw, n_kw;
    logic [ADDR_W-1:0]   r_idx, n_idx;
    // Result register.
    logic        r_out_valid, n_out_valid;
    logic [3:0]  r_kind;
    logic [31:0] r_value;
    logic [7:0]  r_text;
    logic [15:0] r_oline, r_ocol;
    logic        r_ntr, r_tend, r_last;

    // Character classes.
    logic       w_letter, w_digit, w_under, w_wstart, w_nl, w_skip, w_punct, w_err;
    logic [3:0] w_pkind;
    logic       w_tail_emits;

    // Helpers.
    logic [15:0]         w_col_inc, w_line_inc;
    logic [31:0]         w_acc_base;
    logic [35:0]         w_prod;
    logic [31:0]         w_acc_next;
    logic [LEN_W-1:0]    w_pos;
    logic [5:0]          w_pos6;
    logic [KW_COUNT-1:0] w_kw_base, w_kw_step, w_kw_full;
    logic                w_kw_hit;
    logic [3:0]          w_kw_kind;
    logic                w_idx_last;
    logic                w_out_free;

    // Emission.
    logic        w_emit;
    logic [3:0]  e_kind;
    logic [31:0] e_value;
    logic [7:0]  e_text;
    logic [15:0] e_line, e_col;
    logic        e_ntr, e_tend, e_last;

    always_comb begin
        w_letter = ((r_char >= "a") && (r_char <= "z")) || ((r_char >= "A") && (r_char <= "Z"));
        w_digit  = (r_char >= "0") && (r_char <= "9");
        w_under  = (r_char == "_");
        w_wstart = w_letter || w_under;
        w_nl     = (r_char == 8'h0A);
        w_skip   = (r_char == 8'h0D) || (r_char == 8'h0C) || (r_char == " ");
        w_punct  = 1'b1;
        w_pkind  = KIND_ERROR;
        unique case (r_char)
            "(":     w_pkind = KIND_LPAREN;
            ")":     w_pkind = KIND_RPAREN;
            "-":     w_pkind = KIND_MINUS;
            ">":     w_pkind = KIND_GT;
            "{":     w_pkind = KIND_LBRACE;
            "}":     w_pkind = KIND_RBRACE;
            ";":     w_pkind = KIND_SEMI;
            default: w_punct = 1'b0;
        endcase
        w_err        = !(w_punct || w_nl || w_skip || w_wstart || w_digit);
        w_tail_emits = r_end || w_punct || w_err;
    end

    always_comb begin
        w_col_inc  = (r_col == 16'hFFFF) ? r_col : r_col + 16'd1;
        w_line_inc = (r_line == 16'hFFFF) ? r_line : r_line + 16'd1;

        // Decimal accumulate with saturation; a new number starts from zero.
        w_acc_base = i_cmd.cont ? r_acc : '0;
        w_prod     = ({4'b0, w_acc_base} << 3) + ({4'b0, w_acc_base} << 1)
                   + {32'b0, r_char[3:0]};
        w_acc_next = (|w_prod[35:32]) ? 32'hFFFF_FFFF : w_prod[31:0];

        // Keyword tracking: each slot stays live while the prefix matches.
        w_pos     = i_cmd.cont ? r_len : '0;
        w_pos6    = 6'(w_pos);
        w_kw_base = i_cmd.cont ? r_kw : '1;
        for (int k = 0; k < KW_COUNT; k++) begin
            w_kw_step[k] = w_kw_base[k] && (w_pos6 < {3'b000, kw_len(2'(k))})
                         && (r_char == kw_byte(2'(k), w_pos6[2:0]));
            w_kw_full[k] = r_kw[k] && (r_len == LEN_W'(kw_len(2'(k))));
        end
        w_kw_hit  = !r_ovf && (|w_kw_full);
        w_kw_kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (w_kw_full[k]) begin
                w_kw_kind = kw_kind(2'(k));
            end
        end

        w_idx_last = ((LEN_W'(r_idx) + LEN_W'(1)) == r_len);
        w_out_free = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_char  = r_char;
        n_end   = r_end;
        n_mode  = r_mode;
        n_len   = r_len;
        n_ovf   = r_ovf;
        n_acc   = r_acc;
        n_line  = r_line;
        n_col   = r_col;
        n_pline = r_pline;
        n_pcol  = r_pcol;
        n_kw    = r_kw;
        n_idx   = r_idx;

        o_ram_we    = 1'b0;
        o_ram_waddr = w_pos[ADDR_W-1:0];
        o_ram_wdata = r_char;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;

        w_emit  = 1'b0;
        e_kind  = KIND_END;
        e_value = '0;
        e_text  = '0;
        e_line  = r_line;
        e_col   = r_col;
        e_ntr   = 1'b0;
        e_tend  = 1'b1;
        e_last  = 1'b1;

        if (i_cmd.latch) begin
            n_char = i_char;
            n_end  = i_end;
        end

        if (i_cmd.cont) begin
            if (r_mode == MODE_WORD) begin
                if (w_pos < LEN_W'(MAX_WORD_LEN)) begin
                    o_ram_we = 1'b1;
                    n_len    = w_pos + LEN_W'(1);
                    n_kw     = w_kw_step;
                end else begin
                    n_ovf = 1'b1;
                end
            end else begin
                n_acc = w_acc_next;
            end
            n_pline = r_line;
            n_pcol  = r_col;
            n_col   = w_col_inc;
        end

        if (i_cmd.emit_one) begin
            w_emit  = 1'b1;
            e_kind  = (r_mode == MODE_NUMBER) ? KIND_INT : w_kw_kind;
            e_value = (r_mode == MODE_NUMBER) ? r_acc : '0;
            e_line  = r_pline;
            e_col   = r_pcol;
            e_last  = !w_tail_emits;
            n_mode  = MODE_IDLE;
            n_len   = '0;
            n_ovf   = 1'b0;
            n_acc   = '0;
        end

        if (i_cmd.rd_first) begin
            o_ram_re = 1'b1;
            n_idx    = '0;
        end

        if (i_cmd.emit_char) begin
            w_emit = 1'b1;
            e_kind = KIND_IDENT;
            e_text = i_ram_rdata;
            e_line = r_pline;
            e_col  = r_pcol;
            e_ntr  = r_ovf;
            e_tend = w_idx_last;
            e_last = w_idx_last && !w_tail_emits;
            if (w_idx_last) begin
                n_mode = MODE_IDLE;
                n_len  = '0;
                n_ovf  = 1'b0;
                n_acc  = '0;
            end else begin
                o_ram_re    = 1'b1;
                o_ram_raddr = r_idx + ADDR_W'(1);
                n_idx       = r_idx + ADDR_W'(1);
            end
        end

        if (i_cmd.tail) begin
            if (r_end) begin
                w_emit = 1'b1;
                e_kind = KIND_END;
            end else if (w_punct) begin
                w_emit = 1'b1;
                e_kind = w_pkind;
                n_col  = w_col_inc;
            end else if (w_nl) begin
                n_line = w_line_inc;
                n_col  = 16'd1;
            end else if (w_skip) begin
                n_col = w_col_inc;
            end else if (w_wstart) begin
                n_mode   = MODE_WORD;
                n_ovf    = 1'b0;
                o_ram_we = 1'b1;
                n_len    = LEN_W'(1);
                n_kw     = w_kw_step;
                n_pline  = r_line;
                n_pcol   = r_col;
                n_col    = w_col_inc;
            end else if (w_digit) begin
                n_mode  = MODE_NUMBER;
                n_acc   = w_acc_next;
                n_pline = r_line;
                n_pcol  = r_col;
                n_col   = w_col_inc;
            end else begin
                w_emit = 1'b1;
                e_kind = KIND_ERROR;
                e_text = r_char;
                n_mode = MODE_HALTED;
            end
        end

        n_out_valid = w_emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_acc       <= '0;
            r_line      <= 16'd1;
            r_col       <= 16'd1;
            r_pline     <= 16'd1;
            r_pcol      <= 16'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_acc       <= n_acc;
            r_line      <= n_line;
            r_col       <= n_col;
            r_pline     <= n_pline;
            r_pcol      <= n_pcol;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_end  <= n_end;
        r_kw   <= n_kw;
        r_idx  <= n_idx;
        if (w_emit) begin
            r_kind  <= e_kind;
            r_value <= e_value;
            r_text  <= e_text;
            r_oline <= e_line;
            r_ocol  <= e_col;
            r_ntr   <= e_ntr;
            r_tend  <= e_tend;
            r_last  <= e_last;
        end
    end

    always_comb begin
        o_status.halted     = (r_mode == MODE_HALTED);
        o_status.word_mode  = (r_mode == MODE_WORD);
        o_status.num_mode   = (r_mode == MODE_NUMBER);
        o_status.cont_char  = !r_end && (((r_mode == MODE_WORD) && (w_wstart || w_digit))
                            || ((r_mode == MODE_NUMBER) && w_digit));
        o_status.kw_hit     = w_kw_hit;
        o_status.tail_emits = w_tail_emits;
        o_status.out_free   = w_out_free;
        o_status.idx_last   = w_idx_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_value      = r_value;
    assign o_text       = r_text;
    assign o_line       = r_oline;
    assign o_col        = r_ocol;
    assign o_name_trunc = r_ntr;
    assign o_token_end  = r_tend;
    assign o_last       = r_last;

`ifndef NO_ASSERTIONS
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HALTED) |=> (r_mode == MODE_HALTED))
        else $error("halted scanner left the halted mode");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_WORD_LEN))
        else $error("word length beyond buffer size");
    a_word_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_WORD) |-> (r_len != '0))
        else $error("word mode with empty buffer");
    a_num_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_NUMBER) |-> ((r_len == '0) && !r_ovf))
        else $error("number mode with word state left over");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");
`endif

endmodule
`default_nettype wire

/* rtl/keyword_lexer_unit.sv */
// Top level of the keyword lexer: controller, datapath and identifier buffer.
// A byte that extends a word or number, or is skipped, passes the IDLE and DECODE states.
// A byte that ends a keyword or integer passes IDLE, DECODE, ONE and TAIL; one that ends an
// identifier passes IDLE, DECODE, IDENT for each buffered character and TAIL, one character
// per cycle on the output port unless it stalls. Results reach the master side from a register.
// Reset is synchronous and active low; the buffer needs no clearing pass.
`default_nettype none
module keyword_lexer_unit import kl_pkg::*; #(
    parameter int MAX_WORD_LEN = KL_MAX_WORD_LEN
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave side: one request per source byte.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  wire logic [0:0]  s_axis_tuser,   // [0] end_of_input
    // Master side: one request per result.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [71:0] m_axis_tdata,   // [31:0] int_value, [39:32] text_char,
                                             // [55:40] line_no, [71:56] column_no
    output logic      [6:0]  m_axis_tuser,   // [3:0] token_kind, [4] tied to 0,
                                             // [5] name_truncated, [6] token_end
    output logic             m_axis_tlast    // last result caused by one input request
);

    localparam int ADDR_W = $clog2(MAX_WORD_LEN);

    t_cmd        w_cmd;
    t_status     w_status;
    logic        w_ram_we, w_ram_re;
    logic [ADDR_W-1:0] w_ram_waddr, w_ram_raddr;
    logic [7:0]  w_ram_wdata, w_ram_rdata;
    logic [3:0]  w_kind;
    logic [31:0] w_value;
    logic [7:0]  w_text;
    logic [15:0] w_line, w_col;
    logic        w_ntr, w_tend;

    // The controller accepts a request only when it has finished the previous one.
    // A result waiting in the output register does not block the next request.
    kl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the scanner mode, counters, the integer accumulator,
    // keyword prefix tracking and the output register.
    kl_dpath #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (s_axis_tdata),
        .i_end        (s_axis_tuser[0]),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_ram_we     (w_ram_we),
        .o_ram_waddr  (w_ram_waddr),
        .o_ram_wdata  (w_ram_wdata),
        .o_ram_re     (w_ram_re),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_kind       (w_kind),
        .o_value      (w_value),
        .o_text       (w_text),
        .o_line       (w_line),
        .o_col        (w_col),
        .o_name_trunc (w_ntr),
        .o_token_end  (w_tend),
        .o_last       (m_axis_tlast)
    );

    // Identifier characters are written as they arrive and read back one per
    // cycle, while the output is not stalled, when the identifier is flushed.
    kl_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WORD_LEN)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign m_axis_tdata = {w_col, w_line, w_text, w_value};
    assign m_axis_tuser = {w_tend, w_ntr, 1'b0, w_kind};

endmodule
`default_nettype wire
